/* sv/obstacle_avoid_drive_controller_unit_defines.svh */
// assertion macros for the obstacle avoid drive controller
// expects clk and arst_n in the scope where a macro is used
`ifndef OBSTACLE_AVOID_DRIVE_CONTROLLER_UNIT_DEFINES_SVH
`define OBSTACLE_AVOID_DRIVE_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication
`define ODC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ODC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/odc_pkg.sv */
// shared types, codes and constants of the drive controller
// no dependencies
package odc_pkg;

	localparam int ECHO_W  = 16;
	localparam int TICKS_W = 16;
	localparam int CMP_W   = (ECHO_W > TICKS_W) ? ECHO_W : TICKS_W;
	localparam int DUTY_W  = 10;
	localparam int HOLD_W  = 10;
	localparam int CFG_DW  = 16;
	localparam int CFG_AW  = 3;

	// item kinds
	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_SAMPLE = 2'd1;
	localparam logic [1:0] KIND_TICK   = 2'd2;

	// register indexes
	localparam logic [CFG_AW-1:0] REG_SIDE_CLEAR   = 3'd0;
	localparam logic [CFG_AW-1:0] REG_MIDDLE_CLEAR = 3'd1;
	localparam logic [CFG_AW-1:0] REG_AUTO_DUTY    = 3'd2;
	localparam logic [CFG_AW-1:0] REG_TURN_HOLD    = 3'd3;
	localparam logic [CFG_AW-1:0] REG_STOP_HOLD    = 3'd4;
	localparam logic [CFG_AW-1:0] REG_REVERSE_HOLD = 3'd5;
	localparam logic [CFG_AW-1:0] REG_ESCAPE_TURN  = 3'd6;
	localparam logic [CFG_AW-1:0] REG_MANUAL_BASE  = 3'd7;

	// motor nibble: bit0 right fwd, bit1 right rev, bit2 left fwd, bit3 left rev
	localparam logic [3:0] MP_FWD   = 4'h5;
	localparam logic [3:0] MP_REV   = 4'hA;
	localparam logic [3:0] MP_RIGHT = 4'h6;
	localparam logic [3:0] MP_LEFT  = 4'h9;
	localparam logic [3:0] MP_STOP  = 4'h0;

	// rgb: bit0 red, bit1 green, bit2 blue, low lights
	localparam logic [2:0] RGB_RED   = 3'h6;
	localparam logic [2:0] RGB_GREEN = 3'h5;
	localparam logic [2:0] RGB_BLUE  = 3'h3;
	localparam logic [2:0] RGB_OFF   = 3'h7;

	// command characters
	localparam logic [7:0] CH_AUTO     = 8'h41; // A
	localparam logic [7:0] CH_MANUAL   = 8'h4D; // M
	localparam logic [7:0] CH_DIGIT_LO = 8'h30; // 0
	localparam logic [7:0] CH_DIGIT_HI = 8'h39; // 9
	localparam logic [7:0] CH_FWD      = 8'h46; // F
	localparam logic [7:0] CH_BACK     = 8'h42; // B
	localparam logic [7:0] CH_RIGHT    = 8'h52; // R
	localparam logic [7:0] CH_LEFT     = 8'h4C; // L
	localparam logic [7:0] CH_STOP     = 8'h53; // S
	localparam logic [7:0] CH_RED      = 8'h57; // W
	localparam logic [7:0] CH_GREEN    = 8'h58; // X
	localparam logic [7:0] CH_BLUE     = 8'h59; // Y
	localparam logic [7:0] CH_OFF_W    = 8'h77; // w
	localparam logic [7:0] CH_OFF_X    = 8'h78; // x
	localparam logic [7:0] CH_OFF_Y    = 8'h79; // y
	localparam logic [7:0] CH_BUZZ_ON  = 8'h5A; // Z
	localparam logic [7:0] CH_BUZZ_OFF = 8'h7A; // z

	localparam logic [DUTY_W-1:0] DUTY_MAX   = 10'd1023;
	localparam logic [DUTY_W:0]   DIGIT_STEP = 11'd50;

	// reset values
	localparam logic [TICKS_W-1:0] RST_SIDE_CLEAR   = 16'd2206;
	localparam logic [TICKS_W-1:0] RST_MIDDLE_CLEAR = 16'd2574;
	localparam logic [DUTY_W-1:0]  RST_AUTO_DUTY    = 10'd450;
	localparam logic [HOLD_W-1:0]  RST_TURN_HOLD    = 10'd300;
	localparam logic [HOLD_W-1:0]  RST_STOP_HOLD    = 10'd50;
	localparam logic [HOLD_W-1:0]  RST_REVERSE_HOLD = 10'd100;
	localparam logic [HOLD_W-1:0]  RST_ESCAPE_TURN  = 10'd250;
	localparam logic [DUTY_W-1:0]  RST_MANUAL_BASE  = 10'd550;
	localparam logic [DUTY_W-1:0]  RST_SPEED        = 10'd500;

	typedef enum logic [1:0] {
		MODE_NONE,
		MODE_AUTO,
		MODE_MANUAL
	} mode_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_TURN,
		PH_STOP,
		PH_REV,
		PH_ESCTURN
	} phase_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [7:0]        rx_byte;
		logic [ECHO_W-1:0] echo_left;
		logic [ECHO_W-1:0] echo_middle;
		logic [ECHO_W-1:0] echo_right;
	} item_t;

	typedef struct packed {
		logic              right_fwd;
		logic              right_rev;
		logic              left_fwd;
		logic              left_rev;
		logic [DUTY_W-1:0] motor_duty;
		logic              red_pin;
		logic              green_pin;
		logic              blue_pin;
		logic              lamp_pin;
		logic              buzzer_pin;
		logic              auto_active;
		logic              holding;
	} result_t;

	typedef struct packed {
		logic [TICKS_W-1:0] side_clear_ticks;
		logic [TICKS_W-1:0] middle_clear_ticks;
		logic [DUTY_W-1:0]  auto_duty;
		logic [HOLD_W-1:0]  turn_hold_ms;
		logic [HOLD_W-1:0]  stop_hold_ms;
		logic [HOLD_W-1:0]  reverse_hold_ms;
		logic [HOLD_W-1:0]  escape_turn_ms;
		logic [DUTY_W-1:0]  manual_duty_base;
	} cfg_t;

	typedef struct packed {
		mode_t             mode;
		logic [7:0]        latest_byte;
		logic [DUTY_W-1:0] speed;
		logic [3:0]        motor_pins;
		logic [DUTY_W-1:0] duty;
		logic [2:0]        rgb_pins;
		logic              lamp_level;
		logic              buzzer_level;
		logic [HOLD_W-1:0] hold_left;
		phase_t            phase;
		logic              pending_near;
	} state_t;

endpackage

/* sv/odc_cfg_regs.sv */
// configuration register file of the drive controller
// depends on odc_pkg
module odc_cfg_regs import odc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_idx,
	input  logic [CFG_DW-1:0] cfg_wdata,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.side_clear_ticks   <= RST_SIDE_CLEAR;
			cfg_q.middle_clear_ticks <= RST_MIDDLE_CLEAR;
			cfg_q.auto_duty          <= RST_AUTO_DUTY;
			cfg_q.turn_hold_ms       <= RST_TURN_HOLD;
			cfg_q.stop_hold_ms       <= RST_STOP_HOLD;
			cfg_q.reverse_hold_ms    <= RST_REVERSE_HOLD;
			cfg_q.escape_turn_ms     <= RST_ESCAPE_TURN;
			cfg_q.manual_duty_base   <= RST_MANUAL_BASE;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SIDE_CLEAR:   cfg_q.side_clear_ticks   <= cfg_wdata[TICKS_W-1:0];
				REG_MIDDLE_CLEAR: cfg_q.middle_clear_ticks <= cfg_wdata[TICKS_W-1:0];
				REG_AUTO_DUTY:    cfg_q.auto_duty          <= cfg_wdata[DUTY_W-1:0];
				REG_TURN_HOLD:    cfg_q.turn_hold_ms       <= cfg_wdata[HOLD_W-1:0];
				REG_STOP_HOLD:    cfg_q.stop_hold_ms       <= cfg_wdata[HOLD_W-1:0];
				REG_REVERSE_HOLD: cfg_q.reverse_hold_ms    <= cfg_wdata[HOLD_W-1:0];
				REG_ESCAPE_TURN:  cfg_q.escape_turn_ms     <= cfg_wdata[HOLD_W-1:0];
				REG_MANUAL_BASE:  cfg_q.manual_duty_base   <= cfg_wdata[DUTY_W-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/odc_in_reg.sv */
// input register stage: holds one accepted word until the engine takes it
// depends on odc_pkg
module odc_in_reg import odc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	output logic  item_ready,
	input  item_t item,
	input  logic  take,
	output logic  valid_s1,
	output item_t item_s1
);

	logic  vld_s1;
	item_t data_s1;

	assign item_ready = !vld_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item_ready) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			data_s1 <= item;
		end
	end

	assign valid_s1 = vld_s1;
	assign item_s1  = data_s1;

endmodule

/* sv/odc_engine.sv */
// controller state and its single-pass update for one word
// depends on odc_pkg
module odc_engine import odc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    take,
	input  item_t   item_s1,
	output result_t res_d
);

	state_t st_q, st_d;
	logic   near_l, near_m, near_r;

	function automatic state_t drive(state_t s, logic [3:0] pins);
		s.motor_pins = pins;
		s.duty       = s.speed;
		return s;
	endfunction

	function automatic state_t manual_act(state_t s, logic [7:0] b, logic [DUTY_W-1:0] base);
		logic [DUTY_W:0] v;
		v = {1'b0, base} + (DUTY_W+1)'(b[3:0]) * DIGIT_STEP;
		if (b >= CH_DIGIT_LO && b <= CH_DIGIT_HI) begin
			s.speed = (v > {1'b0, DUTY_MAX}) ? DUTY_MAX : v[DUTY_W-1:0];
		end else begin
			unique case (b)
				CH_FWD:   s = drive(s, MP_FWD);
				CH_BACK:  s = drive(s, MP_REV);
				CH_RIGHT: s = drive(s, MP_RIGHT);
				CH_LEFT:  s = drive(s, MP_LEFT);
				CH_STOP:  s = drive(s, MP_STOP);
				CH_RED: begin
					s.lamp_level = 1'b0;
					s.rgb_pins   = RGB_RED;
				end
				CH_GREEN: begin
					s.lamp_level = 1'b0;
					s.rgb_pins   = RGB_GREEN;
				end
				CH_BLUE: begin
					s.lamp_level = 1'b0;
					s.rgb_pins   = RGB_BLUE;
				end
				CH_OFF_W, CH_OFF_X, CH_OFF_Y: s.lamp_level = 1'b1;
				CH_BUZZ_ON:  s.buzzer_level = 1'b0;
				CH_BUZZ_OFF: s.buzzer_level = 1'b1;
				default: ;
			endcase
		end
		return s;
	endfunction

	function automatic state_t indicate(state_t s);
		s.rgb_pins     = s.pending_near ? RGB_RED : RGB_GREEN;
		s.lamp_level   = 1'b0;
		s.buzzer_level = !s.pending_near;
		return s;
	endfunction

	// at most three phase ends can fall in one word: stop, reverse, escape turn
	function automatic state_t advance(state_t s, cfg_t c);
		for (int i = 0; i < 3; i++) begin
			if (s.phase != PH_IDLE && s.hold_left == '0) begin
				unique case (s.phase)
					PH_STOP: begin
						s           = drive(s, MP_REV);
						s.hold_left = c.reverse_hold_ms;
						s.phase     = PH_REV;
					end
					PH_REV: begin
						s           = drive(s, MP_LEFT);
						s.hold_left = c.escape_turn_ms;
						s.phase     = PH_ESCTURN;
					end
					default: begin
						s.phase = PH_IDLE;
						s       = indicate(s);
						if (s.mode == MODE_MANUAL) begin
							s = manual_act(s, s.latest_byte, c.manual_duty_base);
						end
					end
				endcase
			end
		end
		return s;
	endfunction

	function automatic state_t start_hold(state_t s, logic [3:0] pins, phase_t ph,
		logic [HOLD_W-1:0] ms, cfg_t c);
		s           = drive(s, pins);
		s.phase     = ph;
		s.hold_left = ms;
		return advance(s, c);
	endfunction

	assign near_l = CMP_W'(item_s1.echo_left)   < CMP_W'(cfg.side_clear_ticks);
	assign near_m = CMP_W'(item_s1.echo_middle) < CMP_W'(cfg.middle_clear_ticks);
	assign near_r = CMP_W'(item_s1.echo_right)  < CMP_W'(cfg.side_clear_ticks);

	always_comb begin
		st_d = st_q;
		unique case (item_s1.kind)
			KIND_BYTE: begin
				st_d.latest_byte = item_s1.rx_byte;
				if (item_s1.rx_byte == CH_AUTO) begin
					st_d.mode = MODE_AUTO;
				end else if (item_s1.rx_byte == CH_MANUAL) begin
					st_d.mode = MODE_MANUAL;
				end else if (st_q.mode == MODE_MANUAL && st_q.phase == PH_IDLE) begin
					st_d = manual_act(st_d, item_s1.rx_byte, cfg.manual_duty_base);
				end
			end
			KIND_SAMPLE: begin
				if (st_q.mode == MODE_AUTO && st_q.phase == PH_IDLE) begin
					st_d.speed        = cfg.auto_duty;
					st_d.duty         = cfg.auto_duty;
					st_d.pending_near = near_l || near_m || near_r;
					if (near_l && near_m && near_r) begin
						st_d = start_hold(st_d, MP_STOP, PH_STOP, cfg.stop_hold_ms, cfg);
					end else if (near_l) begin
						st_d = start_hold(st_d, MP_RIGHT, PH_TURN, cfg.turn_hold_ms, cfg);
					end else if (near_r) begin
						st_d = start_hold(st_d, MP_LEFT, PH_TURN, cfg.turn_hold_ms, cfg);
					end else if (near_m) begin
						// middle only: turn away from the nearer side; on equal sides only indicate
						if (item_s1.echo_left > item_s1.echo_right) begin
							st_d = start_hold(st_d, MP_LEFT, PH_TURN, cfg.turn_hold_ms, cfg);
						end else if (item_s1.echo_left < item_s1.echo_right) begin
							st_d = start_hold(st_d, MP_RIGHT, PH_TURN, cfg.turn_hold_ms, cfg);
						end else begin
							st_d = indicate(st_d);
						end
					end else begin
						st_d = indicate(drive(st_d, MP_FWD));
					end
				end
			end
			KIND_TICK: begin
				if (st_q.phase != PH_IDLE) begin
					if (st_q.hold_left != '0) begin
						st_d.hold_left = st_q.hold_left - 1'b1;
					end
					st_d = advance(st_d, cfg);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode         <= MODE_NONE;
			st_q.latest_byte  <= '0;
			st_q.speed        <= RST_SPEED;
			st_q.motor_pins   <= MP_STOP;
			st_q.duty         <= '0;
			st_q.rgb_pins     <= RGB_OFF;
			st_q.lamp_level   <= 1'b1;
			st_q.buzzer_level <= 1'b1;
			st_q.hold_left    <= '0;
			st_q.phase        <= PH_IDLE;
			st_q.pending_near <= 1'b0;
		end else if (take) begin
			st_q <= st_d;
		end
	end

	always_comb begin
		res_d.right_fwd   = st_d.motor_pins[0];
		res_d.right_rev   = st_d.motor_pins[1];
		res_d.left_fwd    = st_d.motor_pins[2];
		res_d.left_rev    = st_d.motor_pins[3];
		res_d.motor_duty  = st_d.duty;
		res_d.red_pin     = st_d.rgb_pins[0];
		res_d.green_pin   = st_d.rgb_pins[1];
		res_d.blue_pin    = st_d.rgb_pins[2];
		res_d.lamp_pin    = st_d.lamp_level;
		res_d.buzzer_pin  = st_d.buzzer_level;
		res_d.auto_active = (st_d.mode == MODE_AUTO);
		res_d.holding     = (st_d.phase != PH_IDLE);
	end

endmodule

/* sv/odc_out_reg.sv */
// result register: holds one finished word until the sink takes it
// depends on odc_pkg
module odc_out_reg import odc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_d,
	output logic    space,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	logic    valid_q;
	result_t data_q;

	assign space = !valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res_d;
		end
	end

	assign result_valid = valid_q;
	assign result       = data_q;

endmodule

/* sv/obstacle_avoid_drive_controller_unit.sv */
// path: an accepted word passes the input register, then the result register; it waits longer
// while the result register is held by a stalled sink
// throughput: one word per cycle while the sink takes results; the state update is one
// pass of logic between the input register and the result register
// reset: arst_n clears the state, the registers to their defaults and both valids
// depends on odc_pkg, odc_cfg_regs, odc_in_reg, odc_engine, odc_out_reg
`include "obstacle_avoid_drive_controller_unit_defines.svh"

module obstacle_avoid_drive_controller_unit import odc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_ready,
	output result_t           result,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_idx,
	input  logic [CFG_DW-1:0] cfg_wdata
);

	cfg_t    cfg;
	logic    s1_valid;
	item_t   s1_item;
	logic    space;
	logic    adv;
	result_t res_d;

	assign adv = s1_valid && space;

	odc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	odc_in_reg u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.take       (adv),
		.valid_s1   (s1_valid),
		.item_s1    (s1_item)
	);

	odc_engine u_eng (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.take    (adv),
		.item_s1 (s1_item),
		.res_d   (res_d)
	);

	odc_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (adv),
		.res_d        (res_d),
		.space        (space),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// back pressure only comes from a full input stage behind a stalled result
	`ODC_ASSERT_IMP(a_stall_cause, !item_ready, s1_valid && result_valid && !result_ready, "input stalled without a stalled result")
	// a word leaving the input stage shows up as a result next cycle
	`ODC_ASSERT_NXT(a_adv_result, adv, result_valid, "advanced word did not reach the output")
	// no motor side is driven forward and reverse together
	`ODC_ASSERT_IMP(a_motor_sides, result_valid, !(result.right_fwd && result.right_rev) && !(result.left_fwd && result.left_rev), "motor driven both ways")

endmodule
